// File: sv/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants for the modular exponentiation block
// Field widths, default operand width and sequencer state encoding.
// ----------------------------------------------------------------------------
package mme_pkg;

	localparam int MME_FIELD_WIDTH   = 32;
	localparam int MME_OPERAND_WIDTH = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_BIT,
		ST_MUL,
		ST_SQR,
		ST_FINISH
	} mme_state_t;

endpackage

// File: sv/mme_mulmod.sv
// ----------------------------------------------------------------------------
// mme_mulmod: shared shift-add modular multiplier
// Computes x * y mod m, MSB first over y, one doubling and one conditional
// add per bit, each in its own phase. Needs x <= m, m > 0.
// ----------------------------------------------------------------------------
module mme_mulmod
	import mme_pkg::*;
#(
	parameter int OPERAND_WIDTH = MME_OPERAND_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [OPERAND_WIDTH-1:0] x,
	input  logic [OPERAND_WIDTH-1:0] y,
	input  logic [OPERAND_WIDTH-1:0] m,
	output logic                     done,
	output logic [OPERAND_WIDTH-1:0] result
);

	localparam int W  = OPERAND_WIDTH;
	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          phase_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  r_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  y_q;

	logic [W:0]    m_ext;
	logic [W:0]    dbl_raw;
	logic [W:0]    add_raw;
	logic [W-1:0]  dbl_red;
	logic [W-1:0]  add_red;

	// 2r and r + x both stay below 2m, so one subtract reduces either
	always_comb begin
		m_ext   = {1'b0, m};
		dbl_raw = {r_q, 1'b0};
		add_raw = {1'b0, r_q} + (y_q[W-1] ? {1'b0, x_q} : '0);
		dbl_red = (dbl_raw >= m_ext) ? W'(dbl_raw - m_ext) : W'(dbl_raw);
		add_red = (add_raw >= m_ext) ? W'(add_raw - m_ext) : W'(add_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CW'(W - 1);
			end else if (busy_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			x_q <= x;
			y_q <= y;
		end else if (busy_q) begin
			if (!phase_q) begin
				r_q <= dbl_red;
			end else begin
				r_q <= add_red;
				y_q <= {y_q[W-2:0], 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign result = r_q;

endmodule

// File: sv/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation: right-to-left square-and-multiply exponentiation
// Reduces the base, then walks the exponent from the LSB using one shared
// modular multiplier. Zero modulus returns 0 with modulus_error set.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_ready  | base_value, exponent_value, modulus_value
//  out     | out_valid/out_ready| power_result, modulus_error
//
//  One modular multiply steps through all W = OPERAND_WIDTH bits of y, one
//  bit at a time, in the shared multiplier.
//  An item takes one reduction, then per exponent bit one decision state
//  (ST_BIT) and up to two multiplies, with no square after the highest set
//  bit; a zero modulus skips to ST_FINISH with no multiply.
//  in_ready is high only while the sequencer is idle; the result register
//  lets the next item be taken while a result still waits on out_ready.
//  arst_n clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module modular_exponentiation
	import mme_pkg::*;
#(
	parameter int OPERAND_WIDTH = MME_OPERAND_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [MME_FIELD_WIDTH-1:0] base_value,
	input  logic [MME_FIELD_WIDTH-1:0] exponent_value,
	input  logic [MME_FIELD_WIDTH-1:0] modulus_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [MME_FIELD_WIDTH-1:0] power_result,
	output logic                       modulus_error
);

	localparam int W = OPERAND_WIDTH;

	mme_state_t state_q, state_d;

	logic                       out_valid_q;
	logic [MME_FIELD_WIDTH-1:0] power_result_q;
	logic                       modulus_error_q;

	logic [W-1:0] base_q;
	logic [W-1:0] expo_q;
	logic [W-1:0] mod_q;
	logic [W-1:0] acc_q;
	logic         err_q;

	logic         in_fire;
	logic         out_load;
	logic         mm_start;
	logic [W-1:0] mm_x;
	logic [W-1:0] mm_y;
	logic         mm_done;
	logic [W-1:0] mm_result;

	assign in_fire = in_valid && in_ready;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		mm_start = 1'b0;
		mm_x     = base_q;
		mm_y     = base_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				// reduce the base as 1 * base mod m
				mm_x     = W'(1);
				mm_y     = base_value[W-1:0];
				if (in_valid) begin
					if (modulus_value[W-1:0] == '0) begin
						state_d = ST_FINISH;
					end else begin
						mm_start = 1'b1;
						state_d  = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				if (mm_done) state_d = ST_BIT;
			end
			ST_BIT: begin
				if (expo_q == '0) begin
					state_d = ST_FINISH;
				end else if (expo_q[0]) begin
					mm_x     = acc_q;
					mm_start = 1'b1;
					state_d  = ST_MUL;
				end else begin
					mm_start = 1'b1;
					state_d  = ST_SQR;
				end
			end
			ST_MUL: begin
				if (mm_done) begin
					// no square needed once no higher bit is set
					if (expo_q[W-1:1] == '0) begin
						state_d = ST_FINISH;
					end else begin
						mm_start = 1'b1;
						state_d  = ST_SQR;
					end
				end
			end
			ST_SQR: begin
				if (mm_done) state_d = ST_BIT;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			base_q <= base_value[W-1:0];
			expo_q <= exponent_value[W-1:0];
			mod_q  <= modulus_value[W-1:0];
			err_q  <= (modulus_value[W-1:0] == '0);
			acc_q  <= W'(1);
		end
		if (mm_done) begin
			unique case (state_q)
				ST_REDUCE: base_q <= mm_result;
				ST_MUL:    acc_q  <= mm_result;
				ST_SQR: begin
					base_q <= mm_result;
					expo_q <= expo_q >> 1;
				end
				default: ;
			endcase
		end
		if (out_load) begin
			power_result_q  <= err_q ? '0 : MME_FIELD_WIDTH'(acc_q);
			modulus_error_q <= err_q;
		end
	end

	mme_mulmod #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.x      (mm_x),
		.y      (mm_y),
		.m      (mod_q),
		.done   (mm_done),
		.result (mm_result)
	);

	assign out_valid     = out_valid_q;
	assign power_result  = power_result_q;
	assign modulus_error = modulus_error_q;

endmodule

// File: sv/mme_checker.sv
// ----------------------------------------------------------------------------
// mme_checker: port-level checks for modular_exponentiation
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module mme_checker
	import mme_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [MME_FIELD_WIDTH-1:0] power_result,
	input logic                       modulus_error
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(power_result)
			&& $stable(modulus_error))
		else $error("result changed while stalled");

	// an error item carries a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && modulus_error |-> power_result == '0)
		else $error("error item with nonzero result");

	// the block is busy for at least the cycle after it takes an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accepting an item");

endmodule

bind modular_exponentiation mme_checker u_mme_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.power_result  (power_result),
	.modulus_error (modulus_error)
);
